// ===== sv/scg_pkg.sv =====
// ----------------------------------------------------------------------------
// scg_pkg
// Shared types and constants for the Scharr gradient block.
// ----------------------------------------------------------------------------
package scg_pkg;

    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int MAX_HEIGHT      = 2048;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_W  = 12;
    localparam int ROW_W  = 11;
    localparam int PIX_W  = 8;
    localparam int GRAD_W = 14;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;

    // Register index, taken from paddr[2].
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic emit;
        logic last;
    } t_item_flags;

endpackage

// ===== sv/scg_ram.sv =====
// ----------------------------------------------------------------------------
// scg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/scg_front.sv =====
// ----------------------------------------------------------------------------
// scg_front
// Configuration registers, raster position counters and item classification.
// ----------------------------------------------------------------------------
module scg_front #(
    parameter int MAX_WIDTH = scg_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    input  logic                          i_valid,
    input  logic [scg_pkg::PIX_W-1:0]     i_pixel,
    input  logic                          i_full,
    output logic                          o_push,
    output logic [scg_pkg::PIX_W-1:0]     o_pixel,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_col,
    output scg_pkg::t_item_flags          o_flags
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = ((CW > scg_pkg::CFG_W) ? CW : scg_pkg::CFG_W) + 1;
    localparam int RW = scg_pkg::ROW_W;
    localparam int HW = scg_pkg::CFG_W + 1;

    logic [scg_pkg::CFG_W-1:0] r_width, r_height;
    logic [CW-1:0]             r_col;
    logic [RW-1:0]             r_row;
    logic [scg_pkg::CFG_W-1:0] w_eff, h_eff;
    logic                      cfg_wr, accept, col_end, row_end;

    assign cfg_wr = psel && penable && pwrite;
    assign accept = i_valid && !i_full;

    always_comb begin
        priority if (r_width < 12'd3) begin
            w_eff = 12'd3;
        end else if (XW'(r_width) > XW'(MAX_WIDTH)) begin
            w_eff = scg_pkg::CFG_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
    end

    always_comb begin
        priority if (r_height < 12'd3) begin
            h_eff = 12'd3;
        end else if (HW'(r_height) > HW'(scg_pkg::MAX_HEIGHT)) begin
            h_eff = scg_pkg::CFG_W'(scg_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    assign col_end = (XW'(r_col) + XW'(1)) >= XW'(w_eff);
    assign row_end = (HW'(r_row) + HW'(1)) >= HW'(h_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= scg_pkg::WIDTH_RST;
            r_height <= scg_pkg::HEIGHT_RST;
            r_col    <= '0;
            r_row    <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                scg_pkg::REG_WIDTH:  r_width  <= pwdata[scg_pkg::CFG_W-1:0];
                scg_pkg::REG_HEIGHT: r_height <= pwdata[scg_pkg::CFG_W-1:0];
            endcase
            // Any register write restarts the frame.
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            scg_pkg::REG_WIDTH:  prdata = 32'(r_width);
            scg_pkg::REG_HEIGHT: prdata = 32'(r_height);
        endcase
    end

    assign o_push       = accept;
    assign o_pixel      = i_pixel;
    assign o_col        = r_col;
    assign o_flags.emit = (r_row >= RW'(2)) && (r_col >= CW'(2));
    assign o_flags.last = row_end && col_end;

endmodule

// ===== sv/scg_queue.sv =====
// ----------------------------------------------------------------------------
// scg_queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module scg_queue #(
    parameter int WIDTH = 21,
    parameter int DEPTH = scg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [PW:0]      r_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

// ===== sv/scg_back.sv =====
// ----------------------------------------------------------------------------
// scg_back
// Line memory, 3x3 window, Scharr sums and rounding to the output register.
// ----------------------------------------------------------------------------
module scg_back #(
    parameter int MAX_WIDTH = scg_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  logic [scg_pkg::PIX_W-1:0]     i_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_col,
    input  scg_pkg::t_item_flags          i_flags,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_grad_x,
    output logic [7:0]                    o_grad_y,
    output logic [7:0]                    o_grad_sum,
    output logic                          o_frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = scg_pkg::PIX_W;
    localparam int GW = scg_pkg::GRAD_W;

    function automatic logic signed [GW-1:0] f_ext(input logic [PW-1:0] v);
        return $signed({{(GW-PW){1'b0}}, v});
    endfunction

    // v / 16 rounded half to even, saturated.
    function automatic logic [7:0] f_round4(input logic [11:0] v);
        logic [8:0] q;
        logic       up;
        up = (v[3:0] > 4'd8) || ((v[3:0] == 4'd8) && v[4]);
        q  = {1'b0, v[11:4]} + 9'(up);
        return q[8] ? 8'hFF : q[7:0];
    endfunction

    // v / 32 rounded half to even, saturated.
    function automatic logic [7:0] f_round5(input logic [12:0] v);
        logic [8:0] q;
        logic       up;
        up = (v[4:0] > 5'd16) || ((v[4:0] == 5'd16) && v[5]);
        q  = {1'b0, v[12:5]} + 9'(up);
        return q[8] ? 8'hFF : q[7:0];
    endfunction

    logic                 en;
    // Fetch stage
    logic                 r_a_valid;
    logic [PW-1:0]        r_a_pixel;
    logic [CW-1:0]        r_a_col;
    scg_pkg::t_item_flags r_a_flags;
    // Sum stage
    logic                 r_b_valid, r_b_last;
    logic signed [GW-1:0] r_b_gx, r_b_gy;
    // Output register
    logic                 r_out_valid, r_out_last;
    logic [7:0]           r_out_gx, r_out_gy, r_out_sum;

    logic [PW-1:0]        r_win [3][3];
    logic [PW-1:0]        n_win [3][3];
    logic [2*PW-1:0]      ram_rdata;
    logic signed [GW-1:0] gx, gy;
    logic [GW-1:0]        ax_full, ay_full;
    logic [11:0]          ax, ay;

    // The whole back pipeline moves together; it halts only on a held result.
    assign en    = !r_out_valid || !i_stall;
    assign o_pop = en && !i_empty;

    // Each word holds {row two above, row above} for one column.
    scg_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (en && r_a_valid),
        .i_waddr (r_a_col),
        .i_wdata ({ram_rdata[PW-1:0], r_a_pixel}),
        .i_re    (o_pop),
        .i_raddr (i_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = ram_rdata[2*PW-1:PW];
        n_win[1][2] = ram_rdata[PW-1:0];
        n_win[2][2] = r_a_pixel;
    end

    assign gx = GW'(3)  * (f_ext(n_win[0][2]) - f_ext(n_win[0][0]))
              + GW'(10) * (f_ext(n_win[1][2]) - f_ext(n_win[1][0]))
              + GW'(3)  * (f_ext(n_win[2][2]) - f_ext(n_win[2][0]));
    assign gy = GW'(3)  * (f_ext(n_win[2][0]) - f_ext(n_win[0][0]))
              + GW'(10) * (f_ext(n_win[2][1]) - f_ext(n_win[0][1]))
              + GW'(3)  * (f_ext(n_win[2][2]) - f_ext(n_win[0][2]));

    // Magnitudes never exceed 16 * 255, so twelve bits hold them.
    assign ax_full = r_b_gx[GW-1] ? GW'(-r_b_gx) : GW'(r_b_gx);
    assign ay_full = r_b_gy[GW-1] ? GW'(-r_b_gy) : GW'(r_b_gy);
    assign ax      = ax_full[11:0];
    assign ay      = ay_full[11:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= !i_empty;
            r_b_valid   <= r_a_valid && r_a_flags.emit;
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_pixel <= i_pixel;
            r_a_col   <= i_col;
            r_a_flags <= i_flags;
            if (r_a_valid) begin
                r_win <= n_win;
            end
            r_b_gx     <= gx;
            r_b_gy     <= gy;
            r_b_last   <= r_a_flags.last;
            r_out_gx   <= f_round4(ax);
            r_out_gy   <= f_round4(ay);
            r_out_sum  <= f_round5({1'b0, ax} + {1'b0, ay});
            r_out_last <= r_b_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_grad_x     = r_out_gx;
    assign o_grad_y     = r_out_gy;
    assign o_grad_sum   = r_out_sum;
    assign o_frame_last = r_out_last;

endmodule

// ===== sv/scharr_gradient_3x3.sv =====
// ----------------------------------------------------------------------------
// scharr_gradient_3x3
// 3x3 Scharr edge gradient over a raster stream of 8-bit grey pixels.
// ----------------------------------------------------------------------------
// Path: an accepted pixel is written into the queue, then passes through the fetch
//   stage, the sum stage and the output register before its result shows on o_valid.
// Throughput: one pixel per clock while o_stall is low, set by the line memory's single read port.
// Reset (synchronous, i_rst_n low): counters, valids and queue are cleared and
//   the frame size returns to 640x480; the line memory is not cleared.
module scharr_gradient_3x3 #(
    parameter int MAX_WIDTH   = scg_pkg::MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = scg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_grad_x,
    output logic [7:0]  o_grad_y,
    output logic [7:0]  o_grad_sum,
    output logic        o_frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = scg_pkg::PIX_W + CW + $bits(scg_pkg::t_item_flags);

    logic                         push, pop, q_empty, q_full;
    logic [scg_pkg::PIX_W-1:0]    f_pixel, b_pixel;
    logic [CW-1:0]                f_col, b_col;
    scg_pkg::t_item_flags         f_flags, b_flags;
    logic [QW-1:0]                q_rdata;

    assign pready  = 1'b1;
    assign o_stall = q_full;

    scg_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .i_valid (i_valid),
        .i_pixel (i_pixel),
        .i_full  (q_full),
        .o_push  (push),
        .o_pixel (f_pixel),
        .o_col   (f_col),
        .o_flags (f_flags)
    );

    scg_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_pixel, f_col, f_flags}),
        .i_pop   (pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign {b_pixel, b_col, b_flags} = q_rdata;

    scg_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_pixel      (b_pixel),
        .i_col        (b_col),
        .i_flags      (b_flags),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_grad_x     (o_grad_x),
        .o_grad_y     (o_grad_y),
        .o_grad_sum   (o_grad_sum),
        .o_frame_last (o_frame_last)
    );

endmodule

// ===== sv/scg_checker.sv =====
// ----------------------------------------------------------------------------
// scg_checker
// Port-level checks on the Scharr gradient block's result channel.
// ----------------------------------------------------------------------------
module scg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_grad_x,
    input logic [7:0] o_grad_y,
    input logic [7:0] o_grad_sum
);

    logic [9:0] pair_sum, twice_sum;

    assign pair_sum  = 10'(o_grad_x) + 10'(o_grad_y);
    assign twice_sum = {1'b0, o_grad_sum, 1'b0};

    // A held result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_grad_x) && $stable(o_grad_y)
                               && $stable(o_grad_sum))
        else $error("result changed while stalled");

    // The combined gradient is half the two parts, within one rounding step.
    a_sum_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> twice_sum <= pair_sum + 10'd2)
        else $error("grad_sum too large for grad_x and grad_y");

    a_sum_lower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> twice_sum + 10'd2 >= pair_sum)
        else $error("grad_sum too small for grad_x and grad_y");

    // Reset leaves no result on the port.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind scharr_gradient_3x3 scg_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_grad_x   (o_grad_x),
    .o_grad_y   (o_grad_y),
    .o_grad_sum (o_grad_sum)
);
